// ----- hw/rtl/sipi_pkg.sv -----
package sipi_pkg;

  typedef logic signed [63:0] word_t;

  typedef struct packed {
    logic  start;
    word_t a;
    word_t b;
  } arith_req_t;

  typedef struct packed {
    logic  done;
    word_t res;
  } arith_rsp_t;

  localparam logic [1:0] OP_MATRIX = 2'd0;
  localparam logic [1:0] OP_VECTOR = 2'd1;
  localparam logic [1:0] OP_RUN    = 2'd2;

  localparam logic [1:0] ST_SINGULAR = 2'd0;
  localparam logic [1:0] ST_LIMIT    = 2'd1;
  localparam logic [1:0] ST_CONV     = 2'd2;
  localparam logic [1:0] ST_ZERO     = 2'd3;

  localparam logic [1:0] REG_SIZE = 2'd0;
  localparam logic [1:0] REG_TOL  = 2'd1;
  localparam logic [1:0] REG_ITER = 2'd2;

  localparam word_t W_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam word_t W_MIN = 64'sh8000_0000_0000_0000;

  function automatic logic [63:0] mag(input word_t a);
    return a[63] ? 64'(-a) : 64'(a);
  endfunction

  function automatic word_t apply_sign(input logic [63:0] m, input logic neg);
    if (neg) begin
      if (m > 64'h8000_0000_0000_0000) return W_MIN;
      return word_t'(-m);
    end
    if (m > 64'h7FFF_FFFF_FFFF_FFFF) return W_MAX;
    return word_t'(m);
  endfunction

  function automatic word_t sadd(input word_t a, input word_t b);
    word_t r;
    r = a + b;
    if (a[63] == b[63] && r[63] != a[63]) return a[63] ? W_MIN : W_MAX;
    return r;
  endfunction

  function automatic word_t ssub(input word_t a, input word_t b);
    word_t r;
    r = a - b;
    if (a[63] != b[63] && r[63] != a[63]) return a[63] ? W_MIN : W_MAX;
    return r;
  endfunction

  function automatic word_t sabs(input word_t a);
    if (a == W_MIN) return W_MAX;
    return a[63] ? -a : a;
  endfunction

endpackage

// ----- hw/rtl/sipi_ram.sv -----
module sipi_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 100,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/sipi_mul.sv -----
module sipi_mul import sipi_pkg::*; #(
  parameter int FRAC_BITS = 40
) (
  input  logic       clk,
  input  logic       rst,
  input  arith_req_t req,
  output arith_rsp_t rsp
);

  logic         busy;
  logic [2:0]   cnt;
  logic [63:0]  x;
  logic [63:0]  y;
  logic         neg;
  logic [63:0]  pp;
  logic [1:0]   sh;
  logic [127:0] acc;
  logic [127:0] pp_wide;
  logic         done;
  word_t        res;

  always_comb begin
    case (sh)
      2'd0:    pp_wide = {64'b0, pp};
      2'd1:    pp_wide = {32'b0, pp, 32'b0};
      default: pp_wide = {pp, 64'b0};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        x    <= mag(req.a);
        y    <= mag(req.b);
        neg  <= req.a[63] ^ req.b[63];
        acc  <= '0;
      end else if (busy) begin
        cnt <= cnt + 3'd1;
        case (cnt)
          3'd0: begin
            pp <= 64'(x[31:0]) * 64'(y[31:0]);
            sh <= 2'd0;
          end
          3'd1: begin
            pp  <= 64'(x[31:0]) * 64'(y[63:32]);
            sh  <= 2'd1;
            acc <= acc + pp_wide;
          end
          3'd2: begin
            pp  <= 64'(x[63:32]) * 64'(y[31:0]);
            sh  <= 2'd1;
            acc <= acc + pp_wide;
          end
          3'd3: begin
            pp  <= 64'(x[63:32]) * 64'(y[63:32]);
            sh  <= 2'd2;
            acc <= acc + pp_wide;
          end
          3'd4: begin
            acc <= acc + pp_wide;
          end
          default: begin
            busy <= 1'b0;
            done <= 1'b1;
            if (|acc[127:64+FRAC_BITS]) begin
              res <= apply_sign('1, neg);
            end else begin
              res <= apply_sign(acc[63+FRAC_BITS:FRAC_BITS], neg);
            end
          end
        endcase
      end
    end
  end

  assign rsp.done = done;
  assign rsp.res  = res;

endmodule

// ----- hw/rtl/sipi_div.sv -----
module sipi_div import sipi_pkg::*; #(
  parameter int FRAC_BITS = 40
) (
  input  logic       clk,
  input  logic       rst,
  input  arith_req_t req,
  output arith_rsp_t rsp
);

  typedef enum logic [1:0] {D_IDLE, D_CHECK, D_RUN, D_FIN} dstate_t;

  dstate_t     st;
  logic [63:0] x;
  logic [63:0] d;
  logic        neg;
  logic        a_zero;
  logic        a_neg;
  logic [63:0] rem;
  logic [63:0] lo;
  logic [63:0] q;
  logic [5:0]  cnt;
  logic        done;
  word_t       res;
  logic [63:0] hi;
  logic [64:0] trial;

  assign hi    = x >> (64 - FRAC_BITS);
  assign trial = {rem, lo[63]};

  always_ff @(posedge clk) begin
    if (rst) begin
      st   <= D_IDLE;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      case (st)
        D_IDLE: begin
          if (req.start) begin
            x      <= mag(req.a);
            d      <= mag(req.b);
            neg    <= req.a[63] ^ req.b[63];
            a_zero <= (req.a == '0);
            a_neg  <= req.a[63];
            st     <= D_CHECK;
          end
        end
        D_CHECK: begin
          if (d == '0) begin
            res  <= a_zero ? '0 : (a_neg ? W_MIN : W_MAX);
            done <= 1'b1;
            st   <= D_IDLE;
          end else if (hi >= d) begin
            res  <= apply_sign('1, neg);
            done <= 1'b1;
            st   <= D_IDLE;
          end else begin
            rem <= hi;
            lo  <= x << FRAC_BITS;
            q   <= '0;
            cnt <= '0;
            st  <= D_RUN;
          end
        end
        D_RUN: begin
          if (trial >= {1'b0, d}) begin
            rem <= 64'(trial - {1'b0, d});
            q   <= {q[62:0], 1'b1};
          end else begin
            rem <= trial[63:0];
            q   <= {q[62:0], 1'b0};
          end
          lo  <= {lo[62:0], 1'b0};
          cnt <= cnt + 6'd1;
          if (cnt == 6'd63) begin
            st <= D_FIN;
          end
        end
        D_FIN: begin
          res  <= apply_sign(q, neg);
          done <= 1'b1;
          st   <= D_IDLE;
        end
        default: st <= D_IDLE;
      endcase
    end
  end

  assign rsp.done = done;
  assign rsp.res  = res;

endmodule

// ----- hw/rtl/shifted_inverse_power_iteration.sv -----
// Shifted inverse power iteration on a matrix of up to N_MAX rows, signed fixed point
// with FRAC_BITS fraction bits in 64-bit words. Matrix and start-vector words load one per
// cycle while the block is idle. A run word (op 2) carries the shift; the block then
// stalls its input until it has put out every result word of the run. It factors
// A - pI by LU without pivoting, then iterates scale / forward and back solve / update
// until the change drops below the tolerance, the pass limit is hit or a vector turns
// out zero. All multiplies and divides go through one shared multiplier (64x64 from four
// 32x32 partial products) and one radix-2 divider.
module shifted_inverse_power_iteration import sipi_pkg::*; #(
  parameter int N_MAX     = 10,
  parameter int FRAC_BITS = 40
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [4:0]        paddr,
  input  logic [63:0]       pwdata,
  output logic [63:0]       prdata,
  output logic              pready,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        op,
  input  logic [3:0]        row_index,
  input  logic [3:0]        col_index,
  input  logic signed [63:0] value,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        status,
  output logic signed [63:0] eigenvalue,
  output logic [3:0]        element_index,
  output logic signed [63:0] component,
  output logic              last
);

  localparam int DEPTH = N_MAX * N_MAX;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int IW    = (N_MAX > 1) ? $clog2(N_MAX) : 1;
  localparam int NW    = $clog2(N_MAX + 1);
  localparam word_t ONE_FX = word_t'(64'd1 << FRAC_BITS);

  typedef enum logic [4:0] {
    S_IDLE, S_F_BASE, S_F_BASE_W, S_F_RDA, S_F_RDB, S_F_MUL, S_F_MUL_W, S_F_STORE,
    S_F_DIV_W, S_SCAN, S_SCALE, S_SCALE_W, S_SOLVE_BASE, S_SOLVE_RD, S_SOLVE_MUL,
    S_SOLVE_MUL_W, S_SOLVE_END, S_PIV_RD, S_PIV_DIV, S_PIV_W, S_UPD, S_UPD_W,
    S_CHECK, S_EIG, S_EIG_W, S_EMIT
  } state_t;

  state_t        state;
  logic [3:0]    matrix_size;
  logic [62:0]   tolerance;
  logic [15:0]   max_iterations;
  logic [NW-1:0] n;
  logic [NW-1:0] i;
  logic [NW-1:0] j;
  logic [NW-1:0] k;
  logic          lower;
  logic          bwd;
  logic          scan_w;
  word_t         acc;
  word_t         piv;
  word_t         opa;
  word_t         p;
  word_t         vm;
  word_t         xm;
  word_t         err;
  word_t         best;
  word_t         pick;
  word_t         eig;
  logic [1:0]    stat;
  logic [16:0]   itc;
  word_t         v [N_MAX];
  word_t         w [N_MAX];

  logic          take_in;
  logic          cfg_wr;
  logic [NW-1:0] r;
  logic [NW-1:0] c;
  logic [IW-1:0] v_ridx;
  logic [IW-1:0] w_ridx;
  word_t         v_rd;
  word_t         w_rd;
  word_t         sx;
  word_t         sm;
  word_t         pick_new;
  word_t         upd_d;
  logic [16:0]   itc_next;
  logic [NW-1:0] solve_end;
  logic          emit_go;
  logic          conv;

  logic          m_we;
  logic [AW-1:0] m_waddr;
  logic [AW-1:0] m_raddr;
  logic [63:0]   m_rdata;
  logic          lu_we;
  logic [AW-1:0] lu_waddr;
  word_t         lu_wdata;
  logic [AW-1:0] lu_raddr;
  logic [63:0]   lu_rdata;

  arith_req_t    mreq;
  arith_rsp_t    mrsp;
  arith_req_t    dreq;
  arith_rsp_t    drsp;

  function automatic logic [AW-1:0] ent(input logic [NW-1:0] rr, input logic [NW-1:0] cc);
    return AW'(int'(rr) * N_MAX + int'(cc));
  endfunction

  // config port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    case (paddr[4:3])
      REG_SIZE: prdata = {60'b0, matrix_size};
      REG_TOL:  prdata = {1'b0, tolerance};
      REG_ITER: prdata = {48'b0, max_iterations};
      default:  prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      matrix_size    <= 4'd1;
      tolerance      <= 63'd1099;
      max_iterations <= 16'd100;
    end else if (cfg_wr) begin
      case (paddr[4:3])
        REG_SIZE: matrix_size    <= pwdata[3:0];
        REG_TOL:  tolerance      <= pwdata[62:0];
        REG_ITER: max_iterations <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // datapath selection
  assign in_stall = (state != S_IDLE);
  assign take_in  = in_valid && !in_stall;
  assign r        = lower ? j : i;
  assign c        = lower ? i : j;
  assign v_ridx   = (state == S_SCAN) ? k[IW-1:0] : i[IW-1:0];
  assign w_ridx   = (state == S_SCAN || state == S_SOLVE_MUL) ? k[IW-1:0] : i[IW-1:0];
  assign v_rd     = v[v_ridx];
  assign w_rd     = w[w_ridx];
  assign sx       = scan_w ? w_rd : v_rd;
  assign sm       = sabs(sx);
  assign pick_new = (k == '0 || sm > best) ? (sx[63] ? -sm : sm) : pick;
  assign upd_d    = sabs(ssub(v_rd, drsp.res));
  assign itc_next = itc + 17'd1;
  assign solve_end = bwd ? n : i;
  assign emit_go  = !out_valid || !out_stall;
  assign conv     = (stat == ST_CONV);

  assign m_we    = take_in && op == OP_MATRIX && int'(row_index) < N_MAX
                   && int'(col_index) < N_MAX;
  assign m_waddr = ent(NW'(row_index), NW'(col_index));
  assign m_raddr = ent(r, c);

  always_comb begin
    case (state)
      S_F_RDB:    lu_raddr = ent(k, c);
      S_SOLVE_RD: lu_raddr = ent(i, k);
      S_PIV_RD:   lu_raddr = ent(i, i);
      default:    lu_raddr = ent(r, k);
    endcase
  end

  assign lu_we    = (state == S_F_STORE && !lower) || (state == S_F_DIV_W && drsp.done);
  assign lu_waddr = ent(r, c);
  assign lu_wdata = (state == S_F_DIV_W) ? drsp.res : acc;

  always_comb begin
    mreq.start = (state == S_F_MUL) || (state == S_SOLVE_MUL);
    mreq.a     = (state == S_F_MUL) ? opa : word_t'(lu_rdata);
    mreq.b     = (state == S_F_MUL) ? word_t'(lu_rdata) : w_rd;
  end

  always_comb begin
    dreq.start = 1'b0;
    dreq.a     = acc;
    dreq.b     = piv;
    case (state)
      S_F_STORE: dreq.start = lower;
      S_SCALE: begin
        dreq.start = 1'b1;
        dreq.a     = v_rd;
        dreq.b     = vm;
      end
      S_PIV_DIV: begin
        dreq.start = 1'b1;
        dreq.b     = word_t'(lu_rdata);
      end
      S_UPD: begin
        dreq.start = 1'b1;
        dreq.a     = w_rd;
        dreq.b     = xm;
      end
      S_EIG: begin
        dreq.start = 1'b1;
        dreq.a     = ONE_FX;
        dreq.b     = xm;
      end
      default: ;
    endcase
  end

  sipi_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_mat (
    .clk(clk), .we(m_we), .waddr(m_waddr), .wdata(value),
    .raddr(m_raddr), .rdata(m_rdata)
  );

  sipi_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_lu (
    .clk(clk), .we(lu_we), .waddr(lu_waddr), .wdata(lu_wdata),
    .raddr(lu_raddr), .rdata(lu_rdata)
  );

  sipi_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (.clk(clk), .rst(rst), .req(mreq), .rsp(mrsp));
  sipi_div #(.FRAC_BITS(FRAC_BITS)) u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      p         <= '0;
      itc       <= '0;
      lower     <= 1'b0;
      bwd       <= 1'b0;
      scan_w    <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_EMIT) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (take_in) begin
            if (op == OP_VECTOR && int'(row_index) < N_MAX) begin
              v[IW'(row_index)] <= value;
            end
            if (op == OP_RUN) begin
              p     <= value;
              i     <= '0;
              j     <= '0;
              lower <= 1'b0;
              if (matrix_size == 4'd0) begin
                n <= NW'(1);
              end else if (int'(matrix_size) > N_MAX) begin
                n <= NW'(N_MAX);
              end else begin
                n <= NW'(matrix_size);
              end
              state <= S_F_BASE;
            end
          end
        end
        S_F_BASE: state <= S_F_BASE_W;
        S_F_BASE_W: begin
          acc   <= (r == c) ? ssub(word_t'(m_rdata), p) : word_t'(m_rdata);
          k     <= '0;
          state <= (i != '0) ? S_F_RDA : S_F_STORE;
        end
        S_F_RDA: state <= S_F_RDB;
        S_F_RDB: begin
          opa   <= word_t'(lu_rdata);
          state <= S_F_MUL;
        end
        S_F_MUL: state <= S_F_MUL_W;
        S_F_MUL_W: begin
          if (mrsp.done) begin
            acc   <= ssub(acc, mrsp.res);
            k     <= k + 1'b1;
            state <= (k + 1'b1 < i) ? S_F_RDA : S_F_STORE;
          end
        end
        S_F_STORE: begin
          if (lower) begin
            state <= S_F_DIV_W;
          end else if (j == i && acc == '0) begin
            stat  <= ST_SINGULAR;
            eig   <= p;
            state <= S_EMIT;
          end else begin
            if (j == i) begin
              piv <= acc;
            end
            if (j + 1'b1 < n) begin
              j     <= j + 1'b1;
              state <= S_F_BASE;
            end else if (i + 1'b1 < n) begin
              lower <= 1'b1;
              j     <= i + 1'b1;
              state <= S_F_BASE;
            end else begin
              itc    <= '0;
              scan_w <= 1'b0;
              k      <= '0;
              state  <= S_SCAN;
            end
          end
        end
        S_F_DIV_W: begin
          if (drsp.done) begin
            if (j + 1'b1 < n) begin
              j <= j + 1'b1;
            end else begin
              i     <= i + 1'b1;
              j     <= i + 1'b1;
              lower <= 1'b0;
            end
            state <= S_F_BASE;
          end
        end
        S_SCAN: begin
          best <= (k == '0 || sm > best) ? sm : best;
          pick <= pick_new;
          k    <= k + 1'b1;
          if (k + 1'b1 == n) begin
            if (pick_new == '0) begin
              stat  <= ST_ZERO;
              eig   <= p;
              state <= S_EMIT;
            end else if (scan_w) begin
              xm    <= pick_new;
              i     <= '0;
              err   <= '0;
              state <= S_UPD;
            end else begin
              vm    <= pick_new;
              i     <= '0;
              state <= S_SCALE;
            end
          end
        end
        S_SCALE: state <= S_SCALE_W;
        S_SCALE_W: begin
          if (drsp.done) begin
            v[i[IW-1:0]] <= drsp.res;
            if (i + 1'b1 == n) begin
              i     <= '0;
              bwd   <= 1'b0;
              state <= S_SOLVE_BASE;
            end else begin
              i     <= i + 1'b1;
              state <= S_SCALE;
            end
          end
        end
        S_SOLVE_BASE: begin
          acc <= bwd ? w_rd : v_rd;
          k   <= bwd ? i + 1'b1 : '0;
          if (bwd ? (i + 1'b1 < n) : (i != '0)) begin
            state <= S_SOLVE_RD;
          end else begin
            state <= S_SOLVE_END;
          end
        end
        S_SOLVE_RD:  state <= S_SOLVE_MUL;
        S_SOLVE_MUL: state <= S_SOLVE_MUL_W;
        S_SOLVE_MUL_W: begin
          if (mrsp.done) begin
            acc   <= ssub(acc, mrsp.res);
            k     <= k + 1'b1;
            state <= (k + 1'b1 < solve_end) ? S_SOLVE_RD : S_SOLVE_END;
          end
        end
        S_SOLVE_END: begin
          if (bwd) begin
            state <= S_PIV_RD;
          end else begin
            w[i[IW-1:0]] <= acc;
            if (i + 1'b1 == n) begin
              bwd <= 1'b1;
            end else begin
              i <= i + 1'b1;
            end
            state <= S_SOLVE_BASE;
          end
        end
        S_PIV_RD:  state <= S_PIV_DIV;
        S_PIV_DIV: state <= S_PIV_W;
        S_PIV_W: begin
          if (drsp.done) begin
            w[i[IW-1:0]] <= drsp.res;
            if (i == '0) begin
              scan_w <= 1'b1;
              k      <= '0;
              state  <= S_SCAN;
            end else begin
              i     <= i - 1'b1;
              state <= S_SOLVE_BASE;
            end
          end
        end
        S_UPD: state <= S_UPD_W;
        S_UPD_W: begin
          if (drsp.done) begin
            if (upd_d > err) begin
              err <= upd_d;
            end
            v[i[IW-1:0]] <= drsp.res;
            if (i + 1'b1 == n) begin
              state <= S_CHECK;
            end else begin
              i     <= i + 1'b1;
              state <= S_UPD;
            end
          end
        end
        S_CHECK: begin
          itc <= itc_next;
          if (itc_next > {1'b0, max_iterations}) begin
            stat  <= ST_LIMIT;
            eig   <= p;
            state <= S_EMIT;
          end else if ({1'b0, tolerance} > 64'(err)) begin
            state <= S_EIG;
          end else begin
            scan_w <= 1'b0;
            k      <= '0;
            state  <= S_SCAN;
          end
        end
        S_EIG: state <= S_EIG_W;
        S_EIG_W: begin
          if (drsp.done) begin
            eig   <= sadd(p, drsp.res);
            stat  <= ST_CONV;
            i     <= '0;
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (emit_go) begin
            out_valid     <= 1'b1;
            status        <= stat;
            eigenvalue    <= eig;
            element_index <= conv ? 4'(i) : 4'd0;
            component     <= conv ? v_rd : '0;
            last          <= !conv || (i + 1'b1 == n);
            if (!conv || i + 1'b1 == n) begin
              state <= S_IDLE;
            end else begin
              i <= i + 1'b1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_one_unit: assert property (@(posedge clk) disable iff (rst)
    !(mreq.start && dreq.start))
    else $error("multiplier and divider started together");

  a_mul_done: assert property (@(posedge clk) disable iff (rst)
    mrsp.done |-> (state == S_F_MUL_W || state == S_SOLVE_MUL_W))
    else $error("product arrived outside a multiply wait");

  a_div_done: assert property (@(posedge clk) disable iff (rst)
    drsp.done |-> (state == S_F_DIV_W || state == S_SCALE_W || state == S_PIV_W
                   || state == S_UPD_W || state == S_EIG_W))
    else $error("quotient arrived outside a divide wait");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (state != S_EMIT || $stable(status)))
    else $error("result word overwritten while stalled");

endmodule

// ----- sim/shifted_inverse_power_iteration_tb.sv -----
`timescale 1ns / 100ps

module shifted_inverse_power_iteration_tb;
  import sipi_pkg::*;

  localparam int NM = 10;
  localparam int FB = 40;
  localparam int WATCHDOG = 300000;
  localparam int ITEMS = 380;
  localparam logic [1:0] OP_NONE = 2'd3;
  localparam logic [4:0] ADDR_SIZE = 5'(8 * REG_SIZE);
  localparam logic [4:0] ADDR_TOL = 5'(8 * REG_TOL);
  localparam logic [4:0] ADDR_ITER = 5'(8 * REG_ITER);
  localparam word_t ONE = 64'sd1 <<< FB;

  typedef struct {
    logic [1:0] st;
    word_t      eig;
    logic [3:0] idx;
    word_t      comp;
    logic       fin;
  } eig_result_t;

  typedef struct {
    logic [1:0] op;
    logic [3:0] row;
    logic [3:0] col;
    word_t      val;
    logic       chk;
    logic [1:0] st;
  } stim_row_t;

  logic clk = 0;
  logic rst = 1;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [4:0] paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic pready;
  logic in_valid = 0;
  logic in_stall;
  logic [1:0] op = '0;
  logic [3:0] row_index = '0, col_index = '0;
  logic signed [63:0] value = '0;
  logic out_valid;
  logic out_stall = 0;
  logic [1:0] status;
  logic signed [63:0] eigenvalue, component;
  logic [3:0] element_index;
  logic last;

  word_t mat [NM][NM];
  word_t vec [NM];
  word_t work [NM];
  int unsigned cfg_size = 1;
  logic [63:0] cfg_tol = 64'd1099;
  int unsigned cfg_iter = 100;

  eig_result_t pending_q[$];
  int errors = 0;
  int idle_cycles = 0;
  int hold_req = 0;
  bit calm = 0;
  int sent = 0;

  shifted_inverse_power_iteration DUT (.*);

  always #5 clk = ~clk;

  function automatic logic [63:0] magn(word_t a);
    return a[63] ? 64'(-a) : 64'(a);
  endfunction

  function automatic word_t signed_of(logic [63:0] m, logic neg);
    if (neg) return (m > 64'h8000_0000_0000_0000) ? W_MIN : word_t'(-m);
    return (m > 64'h7FFF_FFFF_FFFF_FFFF) ? W_MAX : word_t'(m);
  endfunction

  function automatic word_t add_sat(word_t a, word_t b);
    word_t r;
    r = a + b;
    if (a[63] == b[63] && r[63] != a[63]) return a[63] ? W_MIN : W_MAX;
    return r;
  endfunction

  function automatic word_t sub_sat(word_t a, word_t b);
    word_t r;
    r = a - b;
    if (a[63] != b[63] && r[63] != a[63]) return a[63] ? W_MIN : W_MAX;
    return r;
  endfunction

  function automatic word_t abs_sat(word_t a);
    if (a == W_MIN) return W_MAX;
    return a[63] ? -a : a;
  endfunction

  function automatic word_t fx_mul(word_t a, word_t b);
    logic [127:0] p;
    p = {64'd0, magn(a)} * {64'd0, magn(b)};
    if (p[127:104] != 0) return signed_of('1, a[63] ^ b[63]);
    return signed_of(p[103:40], a[63] ^ b[63]);
  endfunction

  function automatic word_t fx_div(word_t a, word_t b);
    logic [63:0] x, d;
    logic [103:0] q;
    x = magn(a);
    d = magn(b);
    if (d == 0) return (a == 0) ? 64'sd0 : (a[63] ? W_MIN : W_MAX);
    if ({40'd0, x[63:24]} >= {40'd0, d}) return signed_of('1, a[63] ^ b[63]);
    q = {x, 40'd0} / {40'd0, d};
    return signed_of(q[63:0], a[63] ^ b[63]);
  endfunction

  function automatic word_t dominant(word_t v[NM], int n);
    word_t best, pick, m;
    best = 0;
    pick = 0;
    for (int i = 0; i < n; i++) begin
      m = abs_sat(v[i]);
      if (i == 0 || m > best) begin
        best = m;
        pick = v[i][63] ? -m : m;
      end
    end
    return pick;
  endfunction

  function automatic void push_result(logic [1:0] st, word_t eig, int idx, word_t comp,
                                      logic fin);
    eig_result_t r;
    r.st = st;
    r.eig = eig;
    r.idx = 4'(idx);
    r.comp = comp;
    r.fin = fin;
    pending_q.push_back(r);
  endfunction

  function automatic void solve_shifted(word_t p);
    word_t lu [NM][NM];
    word_t acc, vm, xm, err, q, d;
    int n;
    int unsigned passes;
    n = cfg_size;
    if (n < 1) n = 1;
    if (n > NM) n = NM;
    for (int i = 0; i < n; i++)
      for (int j = 0; j < n; j++) lu[i][j] = mat[i][j];
    for (int i = 0; i < n; i++) lu[i][i] = sub_sat(lu[i][i], p);
    for (int i = 0; i < n; i++) begin
      for (int j = i; j < n; j++) begin
        acc = lu[i][j];
        for (int k = 0; k < i; k++) acc = sub_sat(acc, fx_mul(lu[i][k], lu[k][j]));
        lu[i][j] = acc;
      end
      if (lu[i][i] == 0) begin
        push_result(ST_SINGULAR, p, 0, 0, 1);
        return;
      end
      for (int j = i + 1; j < n; j++) begin
        acc = lu[j][i];
        for (int k = 0; k < i; k++) acc = sub_sat(acc, fx_mul(lu[j][k], lu[k][i]));
        lu[j][i] = fx_div(acc, lu[i][i]);
      end
    end
    passes = 0;
    forever begin
      err = 0;
      vm = dominant(vec, n);
      if (vm == 0) break;
      for (int i = 0; i < n; i++) vec[i] = fx_div(vec[i], vm);
      for (int i = 0; i < n; i++) begin
        acc = vec[i];
        for (int k = 0; k < i; k++) acc = sub_sat(acc, fx_mul(lu[i][k], work[k]));
        work[i] = acc;
      end
      for (int i = n - 1; i >= 0; i--) begin
        acc = work[i];
        for (int k = i + 1; k < n; k++) acc = sub_sat(acc, fx_mul(lu[i][k], work[k]));
        work[i] = fx_div(acc, lu[i][i]);
      end
      xm = dominant(work, n);
      if (xm == 0) break;
      for (int i = 0; i < n; i++) begin
        q = fx_div(work[i], xm);
        d = abs_sat(sub_sat(vec[i], q));
        if (d > err) err = d;
        vec[i] = q;
      end
      passes++;
      if (passes > cfg_iter) begin
        push_result(ST_LIMIT, p, 0, 0, 1);
        return;
      end
      if (64'(err) < cfg_tol) begin
        for (int i = 0; i < n; i++)
          push_result(ST_CONV, add_sat(p, fx_div(ONE, xm)), i, vec[i], i == n - 1);
        return;
      end
    end
    push_result(ST_ZERO, p, 0, 0, 1);
  endfunction

  function automatic void apply_word(logic [1:0] o, logic [3:0] r, logic [3:0] c, word_t v);
    case (o)
      OP_MATRIX: if (r < NM && c < NM) mat[r][c] = v;
      OP_VECTOR: if (r < NM) vec[r] = v;
      OP_RUN: solve_shifted(v);
      default: ;
    endcase
  endfunction

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h, want %h", what, got, want);
    errors++;
  endtask

  task automatic send_word(logic [1:0] o, logic [3:0] r, logic [3:0] c, word_t v);
    int gap;
    bit acc;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(negedge clk);
    end
    op <= o;
    row_index <= r;
    col_index <= c;
    value <= v;
    in_valid <= 1;
    forever begin
      #1;
      acc = !in_stall;
      @(posedge clk);
      if (acc) break;
      @(negedge clk);
    end
    idle_cycles = 0;
    sent++;
    apply_word(o, r, c, v);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 0;
    wait (pending_q.size() == 0);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_reg(logic [4:0] a, logic [63:0] d);
    @(negedge clk);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= a;
    pwdata <= d;
    @(negedge clk);
    penable <= 1;
    @(negedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    case (a)
      ADDR_SIZE: cfg_size = d[3:0];
      ADDR_TOL: cfg_tol = {1'b0, d[62:0]};
      default: cfg_iter = d[15:0];
    endcase
  endtask

  // receiver: stalls, checks, watchdog
  initial begin
    bit got, st;
    int stall_left;
    eig_result_t g, w;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req > 0) begin
        st = 1;
        hold_req--;
      end else if (stall_left > 0) begin
        st = 1;
        stall_left--;
      end else begin
        st = 0;
        stall_left = pick_gap();
      end
      out_stall <= st;
      #1;
      got = out_valid && !st;
      g.st = status;
      g.eig = eigenvalue;
      g.idx = element_index;
      g.comp = component;
      g.fin = last;
      @(posedge clk);
      idle_cycles++;
      if (got) begin
        idle_cycles = 0;
        if (pending_q.size() == 0) begin
          report("unexpected word, status", g.st, 0);
        end else begin
          w = pending_q.pop_front();
          if (g.st !== w.st) report("status", g.st, w.st);
          if (g.eig !== w.eig) report("eigenvalue", g.eig, w.eig);
          if (g.idx !== w.idx) report("element_index", g.idx, w.idx);
          if (g.comp !== w.comp) report("component", g.comp, w.comp);
          if (g.fin !== w.fin) report("last", g.fin, w.fin);
        end
      end
      if (idle_cycles > WATCHDOG) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  function automatic word_t tame(int lo, int hi);
    return (word_t'($urandom_range(0, hi - lo)) + lo) * ONE + word_t'($urandom_range(0, 2**20));
  endfunction

  function automatic word_t wild();
    return word_t'({$urandom, $urandom});
  endfunction

  task automatic load_set(int n, bit full, bit zero_vec);
    for (int i = 0; i < n; i++)
      for (int j = 0; j < n; j++) begin
        if ($urandom_range(0, 19) == 0)
          send_word(OP_NONE, 4'($urandom), 4'($urandom), wild());
        if ($urandom_range(0, 24) == 0)
          send_word(OP_MATRIX, 4'($urandom_range(10, 15)), 4'($urandom), wild());
        send_word(OP_MATRIX, 4'(i), 4'(j),
                  full ? wild() : (i == j ? tame(3 * n, 5 * n) : tame(-2, 2)));
      end
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 24) == 0)
        send_word(OP_VECTOR, 4'($urandom_range(10, 15)), 4'($urandom), wild());
      send_word(OP_VECTOR, 4'(i), 4'($urandom),
                zero_vec ? 64'sd0 : (full ? wild() : tame(-3, 3)));
    end
  endtask

  initial begin
    stim_row_t dir [$];
    stim_row_t t;
    int n, runs, r;
    logic [63:0] tol;
    int unsigned it;
    bit full;

    for (int i = 0; i < NM; i++) begin
      vec[i] = 0;
      work[i] = 0;
      for (int j = 0; j < NM; j++) mat[i][j] = 0;
    end
    dir = '{
      '{OP_MATRIX, 4'd0, 4'd0, 2 * ONE, 1'b0, ST_CONV},
      '{OP_VECTOR, 4'd0, 4'd0, ONE, 1'b0, ST_CONV},
      '{OP_RUN, 4'd0, 4'd0, 64'sd0, 1'b1, ST_CONV},
      '{OP_RUN, 4'd0, 4'd0, 2 * ONE, 1'b1, ST_SINGULAR},
      '{OP_VECTOR, 4'd0, 4'd0, 64'sd0, 1'b0, ST_CONV},
      '{OP_RUN, 4'd0, 4'd0, ONE, 1'b1, ST_ZERO},
      '{OP_NONE, 4'd15, 4'd15, -64'sd1, 1'b0, ST_CONV},
      '{OP_MATRIX, 4'd15, 4'd15, -64'sd1, 1'b0, ST_CONV},
      '{OP_MATRIX, 4'd3, 4'd12, W_MAX, 1'b0, ST_CONV},
      '{OP_VECTOR, 4'd15, 4'd0, W_MAX, 1'b0, ST_CONV},
      '{OP_MATRIX, 4'd0, 4'd0, W_MAX, 1'b0, ST_CONV},
      '{OP_VECTOR, 4'd0, 4'd9, W_MIN, 1'b0, ST_CONV},
      '{OP_RUN, 4'd0, 4'd0, W_MIN, 1'b0, ST_CONV},
      '{OP_MATRIX, 4'd0, 4'd0, W_MIN, 1'b0, ST_CONV},
      '{OP_VECTOR, 4'd0, 4'd0, W_MAX, 1'b0, ST_CONV},
      '{OP_RUN, 4'd0, 4'd0, W_MAX, 1'b0, ST_CONV},
      '{OP_MATRIX, 4'd0, 4'd0, -3 * ONE, 1'b0, ST_CONV},
      '{OP_VECTOR, 4'd0, 4'd0, -ONE, 1'b0, ST_CONV},
      '{OP_RUN, 4'd0, 4'd0, 64'sd1, 1'b0, ST_CONV}
    };

    repeat (7) @(negedge clk);
    rst <= 0;

    foreach (dir[i]) begin
      t = dir[i];
      send_word(t.op, t.row, t.col, t.val);
      if (t.chk && pending_q[$].st != t.st)
        report("directed status", pending_q[$].st, t.st);
    end
    drain();

    // extremes of the registers
    write_reg(ADDR_SIZE, 64'd0);
    write_reg(ADDR_TOL, 64'h7FFF_FFFF_FFFF_FFFF);
    write_reg(ADDR_ITER, 64'd65535);
    send_word(OP_RUN, 4'd0, 4'd0, ONE / 2);
    drain();
    write_reg(ADDR_SIZE, 64'd15);
    write_reg(ADDR_TOL, 64'd0);
    write_reg(ADDR_ITER, 64'd0);
    load_set(NM, 0, 0);
    send_word(OP_RUN, 4'd0, 4'd0, ONE);
    drain();

    for (int ph = 0; sent < ITEMS; ph++) begin
      calm = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      n = (r < 70) ? $urandom_range(1, 3) : (r < 95 ? $urandom_range(4, 6) : NM);
      r = $urandom_range(0, 4);
      tol = (r == 0) ? 64'd0 : (r == 1) ? 64'd1099 : (r == 2) ? 64'h7FFF_FFFF_FFFF_FFFF :
            (r == 3) ? 64'($urandom_range(1 << 20, 1 << 30)) << 6 : {1'b0, $urandom, $urandom};
      it = (n > 6) ? $urandom_range(0, 1) : $urandom_range(0, 8);
      write_reg(ADDR_SIZE, 64'(n));
      write_reg(ADDR_TOL, tol);
      write_reg(ADDR_ITER, 64'(it));
      runs = (ph == 1) ? 3 : $urandom_range(1, 3);
      if (ph == 1) hold_req = 3000;
      for (int k = 0; k < runs; k++) begin
        full = ($urandom_range(0, 6) == 0);
        if (k == 0 || $urandom_range(0, 2) != 0)
          load_set(n, full, $urandom_range(0, 19) == 0);
        if (n == 1 && $urandom_range(0, 4) == 0)
          send_word(OP_RUN, 4'($urandom), 4'($urandom), mat[0][0]);
        else
          send_word(OP_RUN, 4'($urandom), 4'($urandom), full ? wild() : tame(-2, 2));
      end
      drain();
    end

    repeat (100) @(negedge clk);
    if (errors == 0 && pending_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/sipi_pkg.sv
hw/rtl/sipi_ram.sv
hw/rtl/sipi_mul.sv
hw/rtl/sipi_div.sv
hw/rtl/shifted_inverse_power_iteration.sv
sim/shifted_inverse_power_iteration_tb.sv
